/* design/owm_pkg.sv */
package owm_pkg;

    // field and register widths
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int HS_W     = 11;
    localparam int OFS_W    = 11;
    localparam int GAIN_W   = 24;
    localparam int LIM_W    = 15;
    localparam int MWR_W    = 14;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 24;
    localparam int N_WHEEL  = 4;

    // datapath widths, sized to the largest reachable magnitude
    localparam int LEV_W    = 13;
    localparam int LIN_W    = 18;
    localparam int P_W      = 28;
    localparam int M_W      = 39;
    localparam int PR_W     = 55;
    localparam int S_W      = 38;
    localparam int W_W      = 62;
    localparam int R_W      = 30;
    localparam int A_W      = 29;
    localparam int Q_W      = MWR_W;
    localparam int NUM_W    = A_W + Q_W;

    // fraction bits dropped by the two rounding steps
    localparam int FRAC_S   = 16;
    localparam int FRAC_R   = 32;

    localparam logic signed [11:0] INV573_Q16 = 12'sd1144;
    localparam logic signed [16:0] K0707_Q16  = 17'sd46334;

    // per-wheel sign patterns, bit k is wheel k (fr, fl, bl, br)
    localparam logic [N_WHEEL-1:0] LIN_NEG_X = 4'b1001;
    localparam logic [N_WHEEL-1:0] LIN_NEG_Y = 4'b1100;
    localparam logic [N_WHEEL-1:0] LEV_NEG_X = 4'b0011;
    localparam logic [N_WHEEL-1:0] LEV_NEG_Y = 4'b1001;

    localparam logic [HS_W-1:0]   HALF_SPAN_RST = 11'd400;
    localparam logic [OFS_W-1:0]  ROT_OFS_RST   = 11'd0;
    localparam logic [GAIN_W-1:0] RPM_GAIN_RST  = 24'd156038;
    localparam logic [LIM_W-1:0]  MAX_V_RST     = 15'd32767;
    localparam logic [MWR_W-1:0]  MAX_RPM_RST   = 14'd9000;

    typedef enum logic [CFG_AW-1:0] {
        REG_HALF_SPAN     = 3'd0,
        REG_ROT_X         = 3'd1,
        REG_ROT_Y         = 3'd2,
        REG_RPM_GAIN      = 3'd3,
        REG_MAX_VX        = 3'd4,
        REG_MAX_VY        = 3'd5,
        REG_MAX_VW        = 3'd6,
        REG_WHEEL_LIM     = 3'd7
    } cfg_reg_t;

    // what rides alongside the divider
    typedef struct packed {
        logic                              lim;
        logic [N_WHEEL-1:0]                neg;
        logic [N_WHEEL-1:0][OUT_W-1:0]     sat;
    } side_t;

    function automatic logic signed [IN_W-1:0] clamp_v(
        input logic signed [IN_W-1:0] v,
        input logic [LIM_W-1:0]       lim
    );
        logic signed [IN_W-1:0] l;
        l = signed'({1'b0, lim});
        if (v > l)
            return l;
        else if (v < -l)
            return -l;
        return v;
    endfunction

    function automatic logic [OUT_W-1:0] sat16(input logic signed [R_W-1:0] r);
        if (r > R_W'(32767))
            return 16'h7fff;
        else if (r < R_W'(-32768))
            return 16'h8000;
        return r[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] abs16(input logic [OUT_W-1:0] v);
        return v[OUT_W-1] ? OUT_W'(-v) : v;
    endfunction

endpackage

/* design/owm_lane.sv */
module owm_lane
    import owm_pkg::*;
#(
    parameter bit NEG_X = 1'b0,
    parameter bit NEG_Y = 1'b0
) (
    input  logic                    aclk,
    input  logic [5:0]              en,
    input  logic signed [IN_W-1:0]  vx,
    input  logic signed [IN_W-1:0]  vy,
    input  logic signed [IN_W-1:0]  vw,
    input  logic signed [LEV_W-1:0] lever,
    input  logic [GAIN_W-1:0]       gain,
    output logic signed [R_W-1:0]   r
);

    logic signed [LIN_W-1:0] lin_reg, lin_next;
    logic signed [P_W-1:0]   p_reg, p_next;
    logic signed [M_W-1:0]   m_reg, m_next;
    logic signed [PR_W-1:0]  prod_reg, prod_next;
    logic signed [S_W-1:0]   s_reg, s_next;
    logic signed [W_W-1:0]   w_reg, w_next;
    logic signed [R_W-1:0]   r_reg, r_next;
    logic [PR_W-1:0]         rnd_p;
    logic [W_W-1:0]          rnd_w;

    always_comb begin
        lin_next = (NEG_X ? -LIN_W'(vx) : LIN_W'(vx)) + (NEG_Y ? -LIN_W'(vy) : LIN_W'(vy));
        p_next   = P_W'(vw) * P_W'(lever);
        m_next   = (M_W'(lin_reg) <<< FRAC_S) - M_W'(p_reg) * M_W'(INV573_Q16);
        prod_next = PR_W'(m_reg) * PR_W'(K0707_Q16);
        // round half away from zero: add half, minus one when negative, then shift
        rnd_p  = prod_reg + PR_W'(1) * (PR_W'(1) << (FRAC_S - 1)) - PR_W'(prod_reg[PR_W-1]);
        s_next = signed'(rnd_p[FRAC_S +: S_W]);
        w_next = W_W'(s_reg) * W_W'(signed'({1'b0, gain}));
        rnd_w  = w_reg + (W_W'(1) << (FRAC_R - 1)) - W_W'(w_reg[W_W-1]);
        r_next = signed'(rnd_w[FRAC_R +: R_W]);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            lin_reg <= lin_next;
            p_reg   <= p_next;
        end
        if (en[1]) m_reg    <= m_next;
        if (en[2]) prod_reg <= prod_next;
        if (en[3]) s_reg    <= s_next;
        if (en[4]) w_reg    <= w_next;
        if (en[5]) r_reg    <= r_next;
    end

    assign r = r_reg;

endmodule

/* design/owm_div.sv */
module owm_div
    import owm_pkg::*;
#(
    parameter int DEN_W = A_W,
    parameter int QB_W  = Q_W
) (
    input  logic                    aclk,
    input  logic [QB_W-1:0]         en,
    input  logic [DEN_W+QB_W-1:0]   num,
    input  logic [DEN_W-1:0]        den,
    output logic [QB_W-1:0]         quo
);

    // restoring divider, one quotient bit per stage; the quotient must fit QB_W bits
    // qn holds the numerator bits still to come, quotient bits shift in from below
    logic [DEN_W-1:0] rem_reg [QB_W-1];
    logic [DEN_W-1:0] den_reg [QB_W-1];
    logic [QB_W-1:0]  qn_reg  [QB_W];

    for (genvar j = 0; j < QB_W; j++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QB_W-1:0]  qn_in;
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in = num[DEN_W+QB_W-1:QB_W];
            assign den_in = den;
            assign qn_in  = num[QB_W-1:0];
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign qn_in  = qn_reg[j-1];
        end

        assign t    = {rem_in, qn_in[QB_W-1]};
        assign diff = t - {1'b0, den_in};
        assign ge   = (t >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (en[j]) qn_reg[j] <= {qn_in[QB_W-2:0], ge};
        end

        if (j < QB_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en[j]) begin
                    rem_reg[j] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = qn_reg[QB_W-1];

endmodule

/* design/omni_wheel_speed_mixer.sv */
// Four-wheel omni/mecanum speed mixer. Each input beat carries a chassis command
// (vx, vy in mm/s, vw in deg/s); each output beat carries the four wheel speeds in rpm
// and a flag set when all four were scaled down to keep the fastest wheel at the
// configured wheel limit. Fully pipelined: one command per clock while the output is
// not stalled. The depth comes from the two wide multiply-and-round steps per wheel
// and from the proportional limiter, a restoring divider that settles one of its 14
// quotient bits per stage. Internal stages close up bubbles, so the input keeps
// accepting while a result waits, until every stage holds a command. Registers are
// written through cfg_we/cfg_addr/cfg_wdata and should only change while no command
// is in flight.
module omni_wheel_speed_mixer
    import owm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // vx_mm_s, vy_mm_s, vw_deg_s

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,   // rpm_front_right, rpm_front_left,
                                           // rpm_back_left, rpm_back_right
    output logic                m_tuser    // was_limited
);

    localparam int DIV_BASE = 11;
    localparam int NST      = DIV_BASE + Q_W;

    // configuration
    logic [HS_W-1:0]          half_span_reg;
    logic signed [OFS_W-1:0]  rot_x_reg;
    logic signed [OFS_W-1:0]  rot_y_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [LIM_W-1:0]         max_vx_reg;
    logic [LIM_W-1:0]         max_vy_reg;
    logic [LIM_W-1:0]         max_vw_reg;
    logic [MWR_W-1:0]         mwr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_span_reg <= HALF_SPAN_RST;
            rot_x_reg     <= ROT_OFS_RST;
            rot_y_reg     <= ROT_OFS_RST;
            gain_reg      <= RPM_GAIN_RST;
            max_vx_reg    <= MAX_V_RST;
            max_vy_reg    <= MAX_V_RST;
            max_vw_reg    <= MAX_V_RST;
            mwr_reg       <= MAX_RPM_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_HALF_SPAN:     half_span_reg <= cfg_wdata[HS_W-1:0];
                REG_ROT_X:         rot_x_reg     <= signed'(cfg_wdata[OFS_W-1:0]);
                REG_ROT_Y:         rot_y_reg     <= signed'(cfg_wdata[OFS_W-1:0]);
                REG_RPM_GAIN:      gain_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_MAX_VX:        max_vx_reg    <= cfg_wdata[LIM_W-1:0];
                REG_MAX_VY:        max_vy_reg    <= cfg_wdata[LIM_W-1:0];
                REG_MAX_VW:        max_vw_reg    <= cfg_wdata[LIM_W-1:0];
                REG_WHEEL_LIM:     mwr_reg       <= cfg_wdata[MWR_W-1:0];
                default: ;
            endcase
        end
    end

    // rotation levers follow the static config
    logic signed [LEV_W-1:0] lever [N_WHEEL];
    logic signed [LEV_W-1:0] hs_ext, ox_ext, oy_ext;

    always_comb begin
        hs_ext = signed'(LEV_W'(half_span_reg));
        ox_ext = LEV_W'(rot_x_reg);
        oy_ext = LEV_W'(rot_y_reg);
        for (int k = 0; k < N_WHEEL; k++) begin
            lever[k] = hs_ext + (LEV_NEG_X[k] ? -ox_ext : ox_ext)
                              + (LEV_NEG_Y[k] ? -oy_ext : oy_ext);
        end
    end

    // stage valids and enables; a stage loads when empty or when the next one moves
    logic [NST-1:0] v_reg;
    logic [NST:0]   en;
    logic           m_tvalid_reg;

    always_comb begin
        en[NST] = !m_tvalid_reg || m_tready;
        for (int i = NST - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en[0]) v_reg[0] <= s_tvalid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
            if (en[NST]) m_tvalid_reg <= v_reg[NST-1];
        end
    end

    // no beat is taken while in reset
    assign s_tready = en[0] && aresetn;

    // stage 0: clamp
    logic signed [IN_W-1:0] vx_reg, vy_reg, vw_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            vx_reg <= clamp_v(signed'(s_tdata[15:0]),  max_vx_reg);
            vy_reg <= clamp_v(signed'(s_tdata[31:16]), max_vy_reg);
            vw_reg <= clamp_v(signed'(s_tdata[47:32]), max_vw_reg);
        end
    end

    // stages 1..6: per-wheel mix, scale and round
    logic signed [R_W-1:0] r_lane [N_WHEEL];

    for (genvar k = 0; k < N_WHEEL; k++) begin : g_lane
        owm_lane #(
            .NEG_X (LIN_NEG_X[k]),
            .NEG_Y (LIN_NEG_Y[k])
        ) u_lane (
            .aclk  (aclk),
            .en    (en[6:1]),
            .vx    (vx_reg),
            .vy    (vy_reg),
            .vw    (vw_reg),
            .lever (lever[k]),
            .gain  (gain_reg),
            .r     (r_lane[k])
        );
    end

    // stages 7..9: magnitudes and the largest of them
    logic signed [R_W-1:0] r7_reg [N_WHEEL];
    logic signed [R_W-1:0] r8_reg [N_WHEEL];
    logic signed [R_W-1:0] r9_reg [N_WHEEL];
    logic [A_W-1:0]        mag7_reg [N_WHEEL];
    logic [A_W-1:0]        mag8_reg [N_WHEEL];
    logic [A_W-1:0]        mag9_reg [N_WHEEL];
    logic [A_W-1:0]        max01_reg, max23_reg, mx9_reg, mx_next;
    logic                  lim9_reg;

    assign mx_next = (max01_reg > max23_reg) ? max01_reg : max23_reg;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N_WHEEL; k++) begin
            if (en[7]) begin
                r7_reg[k]   <= r_lane[k];
                mag7_reg[k] <= r_lane[k][R_W-1] ? A_W'(R_W'(-r_lane[k])) : A_W'(r_lane[k]);
            end
            if (en[8]) begin
                r8_reg[k]   <= r7_reg[k];
                mag8_reg[k] <= mag7_reg[k];
            end
            if (en[9]) begin
                r9_reg[k]   <= r8_reg[k];
                mag9_reg[k] <= mag8_reg[k];
            end
        end
        if (en[8]) begin
            max01_reg <= (mag7_reg[0] > mag7_reg[1]) ? mag7_reg[0] : mag7_reg[1];
            max23_reg <= (mag7_reg[2] > mag7_reg[3]) ? mag7_reg[2] : mag7_reg[3];
        end
        if (en[9]) begin
            mx9_reg  <= mx_next;
            lim9_reg <= (mx_next > A_W'(mwr_reg));
        end
    end

    // stage 10: numerators for the proportional scale
    logic [NUM_W-1:0] num10_reg [N_WHEEL];
    logic [A_W-1:0]   den10_reg;
    side_t            side10_reg;

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            for (int k = 0; k < N_WHEEL; k++) begin
                num10_reg[k]          <= NUM_W'(mag9_reg[k]) * NUM_W'(mwr_reg);
                side10_reg.neg[k]     <= r9_reg[k][R_W-1];
                side10_reg.sat[k]     <= sat16(r9_reg[k]);
            end
            den10_reg      <= mx9_reg;
            side10_reg.lim <= lim9_reg;
        end
    end

    // stages 11..24: dividers, side info kept in step
    logic [Q_W-1:0] quo [N_WHEEL];
    side_t          side_reg [Q_W];

    for (genvar k = 0; k < N_WHEEL; k++) begin : g_div
        owm_div #(
            .DEN_W (A_W),
            .QB_W  (Q_W)
        ) u_div (
            .aclk (aclk),
            .en   (en[DIV_BASE +: Q_W]),
            .num  (num10_reg[k]),
            .den  (den10_reg),
            .quo  (quo[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en[DIV_BASE]) side_reg[0] <= side10_reg;
        for (int j = 1; j < Q_W; j++) begin
            if (en[DIV_BASE + j]) side_reg[j] <= side_reg[j-1];
        end
    end

    // output register
    logic [N_WHEEL-1:0][OUT_W-1:0] rpm_next;
    logic [N_WHEEL-1:0][OUT_W-1:0] rpm_reg;
    logic                          lim_reg;
    side_t                         side_out;

    always_comb begin
        side_out = side_reg[Q_W-1];
        for (int k = 0; k < N_WHEEL; k++) begin
            if (side_out.lim)
                rpm_next[k] = side_out.neg[k] ? -OUT_W'(quo[k]) : OUT_W'(quo[k]);
            else
                rpm_next[k] = side_out.sat[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NST]) begin
            rpm_reg <= rpm_next;
            lim_reg <= side_out.lim;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rpm_reg;
    assign m_tuser  = lim_reg;

    // a scaled beat never leaves a wheel above the wheel limit
    a_limited_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            abs16(rpm_reg[0]) <= OUT_W'(mwr_reg) && abs16(rpm_reg[1]) <= OUT_W'(mwr_reg) &&
            abs16(rpm_reg[2]) <= OUT_W'(mwr_reg) && abs16(rpm_reg[3]) <= OUT_W'(mwr_reg))
        else $error("limited beat exceeds the wheel limit");

    // input back-pressure only when the whole pipe is full behind a stalled output
    a_ready_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && (&v_reg))
        else $error("input stalled with room in the pipeline");

    // a taken output beat always frees room at the input
    a_take_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> s_tready)
        else $error("input not ready while output beat is taken");

endmodule

/* dv/tb_omni_wheel_speed_mixer.sv */
`timescale 1ns / 1ps

module tb_omni_wheel_speed_mixer;
    import owm_pkg::*;

    localparam int SETTLE_CYCLES = 40;     // pipeline is 26 deep
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 120;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        logic signed [IN_W-1:0] vw;
        logic signed [IN_W-1:0] vy;
        logic signed [IN_W-1:0] vx;
    } chassis_cmd_t;

    // wheel 0 is front right, in the lowest bits
    typedef struct packed {
        logic                          limited;
        logic [N_WHEEL-1:0][OUT_W-1:0] rpm;
    } wheel_set_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    cfg_reg_t          cfg_addr = REG_HALF_SPAN;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [63:0]       m_tdata;
    logic              m_tuser;

    omni_wheel_speed_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // register shadow used for prediction
    longint half_span     = longint'(HALF_SPAN_RST);
    longint rot_x         = 0;
    longint rot_y         = 0;
    longint gain_q16      = longint'(RPM_GAIN_RST);
    longint lim_vx        = longint'(MAX_V_RST);
    longint lim_vy        = longint'(MAX_V_RST);
    longint lim_vw        = longint'(MAX_V_RST);
    longint lim_wheel_rpm = longint'(MAX_RPM_RST);

    chassis_cmd_t cmd_q[$];
    wheel_set_t   wheel_expect_q[$];
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int           rx_hold_cycles = 0;
    int           mismatches     = 0;
    bit           s_beat_taken   = 0;
    wheel_set_t   got_set;
    wheel_set_t   want_set;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic string wheel_name(input int k);
        case (k)
            0: return "rpm_front_right";
            1: return "rpm_front_left";
            2: return "rpm_back_left";
            default: return "rpm_back_right";
        endcase
    endfunction

    // v / 2^n rounded to nearest, ties away from zero
    function automatic longint round_shift(input longint v, input int n);
        longint u;
        u = (v < 0) ? -v : v;
        u = (u + (longint'(1) << (n - 1))) >>> n;
        return (v < 0) ? -u : u;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic wheel_set_t mix_wheels(input chassis_cmd_t cmd);
        longint     vx, vy, vw, m, s, w, a, q, peak;
        longint     lever[N_WHEEL];
        longint     lin[N_WHEEL];
        longint     r[N_WHEEL];
        wheel_set_t res;
        vx = clamp_to(longint'(cmd.vx), lim_vx);
        vy = clamp_to(longint'(cmd.vy), lim_vy);
        vw = clamp_to(longint'(cmd.vw), lim_vw);
        lever[0] = half_span - rot_x - rot_y;
        lever[1] = half_span - rot_x + rot_y;
        lever[2] = half_span + rot_x + rot_y;
        lever[3] = half_span + rot_x - rot_y;
        lin[0] = -vx + vy;
        lin[1] = vx + vy;
        lin[2] = vx - vy;
        lin[3] = -vx - vy;
        peak = 0;
        for (int k = 0; k < N_WHEEL; k++) begin
            m = lin[k] * 65536 - vw * lever[k] * longint'(INV573_Q16);
            s = round_shift(m * longint'(K0707_Q16), FRAC_S);
            w = s * gain_q16;
            r[k] = round_shift(w, FRAC_R);
            a = (r[k] < 0) ? -r[k] : r[k];
            if (a > peak)
                peak = a;
        end
        res.limited = (peak > lim_wheel_rpm);
        for (int k = 0; k < N_WHEEL; k++) begin
            if (res.limited) begin
                a = (r[k] < 0) ? -r[k] : r[k];
                q = (a * lim_wheel_rpm) / peak;
                res.rpm[k] = OUT_W'((r[k] < 0) ? -q : q);
            end else if (r[k] > 32767) begin
                res.rpm[k] = 16'h7fff;
            end else if (r[k] < -32768) begin
                res.rpm[k] = 16'h8000;
            end else begin
                res.rpm[k] = OUT_W'(r[k]);
            end
        end
        return res;
    endfunction

    function automatic logic [IN_W-1:0] random_speed(input longint lim);
        longint v;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            1, 2: v = longint'($urandom_range(65535));
            3: begin
                // around the clamp limit, either sign
                v = lim + longint'($urandom_range(6)) - 3;
                if ($urandom_range(1) == 1)
                    v = -v;
            end
            default: v = longint'($urandom_range(3000)) - 1500;
        endcase
        return IN_W'(v);
    endfunction

    function automatic chassis_cmd_t random_cmd();
        chassis_cmd_t c;
        c.vx = random_speed(lim_vx);
        c.vy = random_speed(lim_vy);
        c.vw = random_speed(lim_vw);
        return c;
    endfunction

    task automatic push_cmd(input longint vx, input longint vy, input longint vw);
        chassis_cmd_t c;
        c.vx = IN_W'(vx);
        c.vy = IN_W'(vy);
        c.vw = IN_W'(vw);
        cmd_q.push_back(c);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input longint value);
        logic [CFG_DW-1:0] word;
        logic [CFG_DW-1:0] mask;
        int                w;
        case (idx)
            REG_HALF_SPAN:           w = HS_W;
            REG_ROT_X, REG_ROT_Y:    w = OFS_W;
            REG_RPM_GAIN:            w = GAIN_W;
            REG_WHEEL_LIM:           w = MWR_W;
            default:                 w = LIM_W;
        endcase
        mask = CFG_DW'((longint'(1) << w) - 1);
        word = CFG_DW'(value) & mask;
        // junk above the register width must be dropped by the block
        if ($urandom_range(1) == 1)
            word = word | (CFG_DW'($urandom()) & ~mask);
        case (idx)
            REG_HALF_SPAN:     half_span = longint'(word[HS_W-1:0]);
            REG_ROT_X:         rot_x = longint'($signed(word[OFS_W-1:0]));
            REG_ROT_Y:         rot_y = longint'($signed(word[OFS_W-1:0]));
            REG_RPM_GAIN:      gain_q16 = longint'(word[GAIN_W-1:0]);
            REG_MAX_VX:        lim_vx = longint'(word[LIM_W-1:0]);
            REG_MAX_VY:        lim_vy = longint'(word[LIM_W-1:0]);
            REG_MAX_VW:        lim_vw = longint'(word[LIM_W-1:0]);
            REG_WHEEL_LIM:     lim_wheel_rpm = longint'(word[MWR_W-1:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= word;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input longint hs, input longint ox, input longint oy,
                             input longint gain, input longint mvx, input longint mvy,
                             input longint mvw, input longint mwr);
        write_reg(REG_HALF_SPAN, hs);
        write_reg(REG_ROT_X, ox);
        write_reg(REG_ROT_Y, oy);
        write_reg(REG_RPM_GAIN, gain);
        write_reg(REG_MAX_VX, mvx);
        write_reg(REG_MAX_VY, mvy);
        write_reg(REG_MAX_VW, mvw);
        write_reg(REG_WHEEL_LIM, mwr);
    endtask

    function automatic longint pick_limit(input longint top);
        case ($urandom_range(5))
            0: return 0;
            1: return top;
            2: return longint'($urandom_range(2000));
            default: return longint'($urandom_range(top));
        endcase
    endfunction

    task automatic random_setup();
        longint hs, ox, oy, gain;
        case ($urandom_range(4))
            0: hs = 0;
            1: hs = 2047;
            default: hs = longint'($urandom_range(100, 1200));
        endcase
        case ($urandom_range(4))
            0: ox = -1024;
            1: ox = 1023;
            2: ox = 0;
            default: ox = longint'($urandom_range(600)) - 300;
        endcase
        case ($urandom_range(4))
            0: oy = -1024;
            1: oy = 1023;
            2: oy = 0;
            default: oy = longint'($urandom_range(600)) - 300;
        endcase
        case ($urandom_range(6))
            0: gain = 0;
            1: gain = 24'hffffff;
            2: gain = longint'(RPM_GAIN_RST);
            3: gain = longint'($urandom_range(24'hffffff));
            default: gain = longint'($urandom_range(20000, 400000));
        endcase
        write_all(hs, ox, oy, gain, pick_limit(32767), pick_limit(32767),
                  pick_limit(32767), pick_limit(16383));
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || s_tvalid || wheel_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // input side driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_beat_taken)) begin
            s_beat_taken = 0;
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= cmd_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with an optional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            wheel_expect_q.push_back(mix_wheels(chassis_cmd_t'(s_tdata)));
            s_beat_taken = 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_set = {m_tuser, m_tdata};
            if (wheel_expect_q.size() == 0) begin
                $error("result beat with no command pending: tdata %h tuser %b",
                       m_tdata, m_tuser);
                mismatches++;
            end else begin
                want_set = wheel_expect_q.pop_front();
                for (int k = 0; k < N_WHEEL; k++) begin
                    if (got_set.rpm[k] !== want_set.rpm[k]) begin
                        $error("%s: expected %0d, actual %0d", wheel_name(k),
                               $signed(want_set.rpm[k]), $signed(got_set.rpm[k]));
                        mismatches++;
                    end
                end
                if (got_set.limited !== want_set.limited) begin
                    $error("was_limited: expected %0d, actual %0d",
                           want_set.limited, got_set.limited);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed beats at reset settings
        push_cmd(0, 0, 0);
        push_cmd(32767, 0, 0);
        push_cmd(-32768, 0, 0);
        push_cmd(0, 32767, 0);
        push_cmd(0, -32768, 0);
        push_cmd(0, 0, 32767);
        push_cmd(0, 0, -32768);
        push_cmd(32767, 32767, 32767);
        push_cmd(-32768, -32768, -32768);
        push_cmd(32767, -32768, 1);
        push_cmd(1000, -700, 90);
        push_cmd(-2500, 1200, -45);
        push_cmd(1, 0, 0);
        push_cmd(0, 0, 1);
        push_cmd(-1, -1, -1);
        push_cmd(5000, 0, 0);
        push_cmd(5348, 0, 0);
        push_cmd(0, 0, 400);
        wait_drained();

        // zero clamp limits on vx and vw, a vy limit of one, and zero wheel limit
        write_all(0, -1024, 1023, longint'(RPM_GAIN_RST), 0, 1, 0, 0);
        push_cmd(0, 0, 0);
        push_cmd(32767, 32767, 32767);
        push_cmd(-32768, -32768, -32768);
        push_cmd(100, 0, -100);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_all(2047, 1023, -1024, 24'hffffff, 32767, 32767, 32767, 16383);
                1: write_all(2047, -1024, 1023, 24'hffffff, 0, 0, 0, 0);
                2: write_all(400, 0, 0, 0, 32767, 32767, 32767, 9000);
                3: write_all(0, 1023, 1023, longint'(RPM_GAIN_RST), 32767, 32767,
                             32767, 16383);
                default: random_setup();
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            // fill the pipeline while the result side is held off
            if (ph == 4)
                rx_hold_cycles = LONG_HOLD;
            repeat (PHASE_ITEMS) cmd_q.push_back(random_cmd());
            wait_drained();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
